### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### sv/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Types, codes and constant position tables for the SECDED codec.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

   localparam int MAX_PARITY    = 6;
   localparam int MIN_PARITY    = 2;
   localparam int BLOCK_BITS    = 64;
   localparam int DATA_BITS_MAX = 57;
   localparam int SYN_BITS      = 6;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   localparam logic [1:0] ST_CLEAN  = 2'd0;
   localparam logic [1:0] ST_FIXED  = 2'd1;
   localparam logic [1:0] ST_DOUBLE = 2'd2;

   typedef logic [2:0] parity_type;

   typedef struct packed {
      logic        command;
      logic [63:0] in_word;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] out_word;
      logic [1:0]  status;
   } rsp_payload_type;

   typedef logic [5:0] pos_table_type [DATA_BITS_MAX];
   typedef logic [SYN_BITS-1:0][BLOCK_BITS-1:0] col_table_type;

   // stream position of each data bit
   function automatic pos_table_type build_data_pos();
      pos_table_type tbl;
      int unsigned   j;
      int unsigned   x;
      j = 0;
      for (int unsigned pos = 0; pos < BLOCK_BITS; pos++) begin
         x = pos + 1;
         if ((x & (x - 1)) != 0) begin
            tbl[j] = 6'(pos);
            j++;
         end
      end
      return tbl;
   endfunction

   // positions covered by check bit k, last position excluded
   function automatic col_table_type build_col_mask();
      col_table_type tbl;
      tbl = '0;
      for (int unsigned k = 0; k < SYN_BITS; k++) begin
         for (int unsigned pos = 0; pos < BLOCK_BITS - 1; pos++) begin
            tbl[k][pos] = 1'(((pos + 1) >> k) & 1);
         end
      end
      return tbl;
   endfunction

   localparam pos_table_type DATA_POS = build_data_pos();
   localparam col_table_type COL_MASK = build_col_mask();

   function automatic parity_type clamp_parity(input logic [2:0] value);
      parity_type res;
      if (value < 3'(MIN_PARITY)) begin
         res = 3'(MIN_PARITY);
      end else if (value > 3'(MAX_PARITY)) begin
         res = 3'(MAX_PARITY);
      end else begin
         res = value;
      end
      return res;
   endfunction

   function automatic logic [BLOCK_BITS-1:0] block_mask(input parity_type p);
      logic [BLOCK_BITS-1:0] res;
      case (p)
         3'd2:    res = 64'h0000_0000_0000_000F;
         3'd3:    res = 64'h0000_0000_0000_00FF;
         3'd4:    res = 64'h0000_0000_0000_FFFF;
         3'd5:    res = 64'h0000_0000_FFFF_FFFF;
         default: res = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return res;
   endfunction

   function automatic logic [BLOCK_BITS-1:0] data_mask(input parity_type p);
      logic [BLOCK_BITS-1:0] res;
      case (p)
         3'd2:    res = 64'h0000_0000_0000_0001;
         3'd3:    res = 64'h0000_0000_0000_000F;
         3'd4:    res = 64'h0000_0000_0000_07FF;
         3'd5:    res = 64'h0000_0000_03FF_FFFF;
         default: res = 64'h01FF_FFFF_FFFF_FFFF;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

### sv/hsc_core.sv
// ----------------------------------------------------------------------------
// hsc_core
// Combinational SECDED encode / syndrome-correct-extract for one block.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_core (
   input  wire hsc_pkg::parity_type      parity,
   input  wire hsc_pkg::req_payload_type req,
   output hsc_pkg::rsp_payload_type      rsp
);
   import hsc_pkg::*;

   logic [BLOCK_BITS-1:0] blk_mask;
   logic [BLOCK_BITS-1:0] body_mask;
   logic [BLOCK_BITS-1:0] cap_mask;
   logic [5:0]            top_pos;

   logic [BLOCK_BITS-1:0] enc_data;
   logic [BLOCK_BITS-1:0] enc_scatter;
   logic [SYN_BITS-1:0]   enc_par;
   logic [BLOCK_BITS-1:0] enc_checked;
   logic                  enc_overall;
   logic [BLOCK_BITS-1:0] enc_word;

   logic [BLOCK_BITS-1:0] dec_body;
   logic [SYN_BITS-1:0]   dec_syn;
   logic                  dec_overall;
   logic [BLOCK_BITS-1:0] dec_flip;
   logic [BLOCK_BITS-1:0] dec_fixed;
   logic [BLOCK_BITS-1:0] dec_gather;
   logic [1:0]            dec_status;

   assign blk_mask  = block_mask(parity);
   assign body_mask = blk_mask >> 1;
   assign cap_mask  = data_mask(parity);
   assign top_pos   = 6'((7'd1 << parity) - 7'd1);

   // encode
   assign enc_data = req.in_word & cap_mask;

   always_comb begin
      enc_scatter = '0;
      for (int j = 0; j < DATA_BITS_MAX; j++) begin
         enc_scatter[DATA_POS[j]] = enc_data[j];
      end
   end

   always_comb begin
      enc_checked = enc_scatter;
      for (int k = 0; k < SYN_BITS; k++) begin
         enc_par[k] = (^(enc_scatter & COL_MASK[k])) & (3'(k) < parity);
         enc_checked[(1 << k) - 1] = enc_par[k];
      end
   end

   assign enc_overall = ^(enc_checked & body_mask);
   assign enc_word    = enc_checked | (BLOCK_BITS'(enc_overall) << top_pos);

   // decode
   assign dec_body    = req.in_word & body_mask;
   assign dec_overall = ^(req.in_word & blk_mask);

   always_comb begin
      for (int k = 0; k < SYN_BITS; k++) begin
         dec_syn[k] = ^(dec_body & COL_MASK[k]);
      end
   end

   always_comb begin
      dec_flip   = '0;
      dec_status = ST_CLEAN;
      if (dec_syn != '0) begin
         if (dec_overall) begin
            dec_flip   = BLOCK_BITS'(1) << (dec_syn - 6'd1);
            dec_status = ST_FIXED;
         end else begin
            dec_status = ST_DOUBLE;
         end
      end else if (dec_overall) begin
         dec_status = ST_FIXED;
      end
   end

   assign dec_fixed = req.in_word ^ dec_flip;

   always_comb begin
      dec_gather = '0;
      for (int j = 0; j < DATA_BITS_MAX; j++) begin
         dec_gather[j] = dec_fixed[DATA_POS[j]];
      end
   end

   always_comb begin
      if (req.command == CMD_DECODE) begin
         rsp.out_word = dec_gather & cap_mask;
         rsp.status   = dec_status;
      end else begin
         rsp.out_word = enc_word;
         rsp.status   = ST_CLEAN;
      end
   end

endmodule

`default_nettype wire

### sv/hamming_secded_codec.sv
// ----------------------------------------------------------------------------
// hamming_secded_codec
// Extended Hamming SECDED encoder/decoder, block of 2^p bits, p = 2..6.
// ----------------------------------------------------------------------------
//  channel  ports                         direction
//  req      req_valid/req_stall/req_data  in:  command, in_word
//  rsp      rsp_valid/rsp_stall/rsp_data  out: out_word, status
//  csr      csr_valid/csr_ready/csr_data  in:  parity_bits (3 bits)
//
//  Two register stages: request register, then response register; the
//  XOR trees sit between them. One request per cycle unless a stalled response backs up.
//  Synchronous reset clears both valid flags and sets parity_bits to 6.
//  A stalled response holds; the request register still fills behind it.
//  csr_ready is always high; parity is clamped to 2..6 when written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hamming_secded_codec (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire hsc_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output hsc_pkg::rsp_payload_type      rsp_data,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire  [2:0]                    csr_data
);
   import hsc_pkg::*;

   parity_type      parity_ff,    parity_in;
   logic            s1_valid_ff,  s1_valid_in;
   req_payload_type s1_data_ff,   s1_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff,  rsp_data_in;
   rsp_payload_type core_rsp;
   logic            s2_move;
   logic            s1_move;
   logic            s1_encode;

   hsc_core u_core (
      .parity (parity_ff),
      .req    (s1_data_ff),
      .rsp    (core_rsp)
   );

   assign csr_ready = 1'b1;
   assign s2_move   = !(rsp_valid_ff && rsp_stall);
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_stall = !s1_move;
   assign s1_encode = s1_valid_ff && (s1_data_ff.command == CMD_ENCODE);

   always_comb begin
      parity_in = parity_ff;
      if (csr_valid && csr_ready) begin
         parity_in = clamp_parity(csr_data);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (s1_move) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s2_move) begin
         rsp_valid_in = s1_valid_ff;
         rsp_data_in  = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff    <= 3'(MAX_PARITY);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         parity_ff    <= parity_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_ALWAYS(a_parity_range, clock, reset, parity_ff == clamp_parity(parity_ff))
   `ASSERT_NEXT(a_req_load, clock, reset, req_valid && !req_stall, s1_valid_ff)
   `ASSERT_NEXT(a_stage_advance, clock, reset, s1_valid_ff && s2_move, rsp_valid_ff)
   `ASSERT_IMPLIES(a_encode_clean, clock, reset, s1_encode, core_rsp.status == ST_CLEAN)
   `ASSERT_IMPLIES(a_encode_even, clock, reset, s1_encode, ^core_rsp.out_word == 1'b0)

endmodule

`default_nettype wire
